>>> sv/cmr_pkg.sv
package cmr_pkg;

   localparam int MAX_SUBJECTS = 64;
   localparam int FRAC_BITS    = 16;
   localparam int ADDR_W       = $clog2(MAX_SUBJECTS);
   localparam int DEATH_W      = ADDR_W + 1;
   localparam int TIME_W       = 32;
   localparam int SCORE_W      = 32;
   localparam int RISK_W       = SCORE_W + ADDR_W;
   localparam int HAZ_W        = 48;
   localparam int DIV_W        = RISK_W + ADDR_W;
   localparam int MUL_A_W      = RISK_W;
   localparam int MUL_B_W      = 32;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;
   localparam int RES_W        = 32;

   localparam logic [HAZ_W-1:0] SAT_HAZ = '1;
   localparam logic [DIV_W-1:0] ONE_2F  = DIV_W'(1) << (2 * FRAC_BITS);
   localparam logic [40:0]      PROD_CAP = 41'(1) << 40;

   typedef struct packed {
      logic [TIME_W-1:0]  event_time;
      logic               status;
      logic               stratum;
      logic [SCORE_W-1:0] score;
   } subj_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [HAZ_W-1:0] sat_add(input logic [HAZ_W-1:0] a,
                                                input logic [HAZ_W-1:0] b);
      logic [HAZ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[HAZ_W] ? SAT_HAZ : s[HAZ_W-1:0];
   endfunction

endpackage

>>> sv/cox_martingale_residual.sv
// Martingale residuals of a Cox model. Subjects load one beat per cycle while
// busy is low, sorted by time within strata; the beat with last_subject set
// (or the 64th) starts the compute, and busy stays high until every residual
// has gone out. The receiver cannot stall: each residual is shown for exactly
// one cycle with rsp_valid, in load order, and rsp_last_result marks the
// final one. Compute time is set by one shared restoring divider and one
// registered multiplier, through a backward risk-set pass, a forward pass
// and the emission of each residual, with at most one divide per Breslow tie
// group with deaths and up to three divides per tied death in an Efron group
// of two or more deaths. csr_wdata selects Efron tie handling when 1; write it
// only while busy is low.
module cox_martingale_residual
   import cmr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [TIME_W-1:0]        req_event_time,
   input  logic                     req_event_status,
   input  logic                     req_stratum_end,
   input  logic [SCORE_W-1:0]       req_risk_score,
   input  logic                     req_last_subject,
   output logic                     rsp_valid,
   output logic signed [RES_W-1:0]  rsp_residual,
   output logic                     rsp_last_result,
   input  logic                     csr_we,
   input  logic                     csr_wdata
);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_BK_RD      = 5'd1;
   localparam logic [4:0] S_BK_PROC    = 5'd2;
   localparam logic [4:0] S_BK_FIN     = 5'd3;
   localparam logic [4:0] S_F_RD       = 5'd4;
   localparam logic [4:0] S_F_PROC     = 5'd5;
   localparam logic [4:0] S_F_NEXT     = 5'd6;
   localparam logic [4:0] S_G_START    = 5'd7;
   localparam logic [4:0] S_B_WAIT     = 5'd8;
   localparam logic [4:0] S_E_CUT_MUL  = 5'd9;
   localparam logic [4:0] S_E_CUT_GO   = 5'd10;
   localparam logic [4:0] S_E_CUT_WAIT = 5'd11;
   localparam logic [4:0] S_E_HAZ      = 5'd12;
   localparam logic [4:0] S_E_HAZ_WAIT = 5'd13;
   localparam logic [4:0] S_E_DT_GO    = 5'd14;
   localparam logic [4:0] S_E_DT_WAIT  = 5'd15;
   localparam logic [4:0] S_R_RD       = 5'd16;
   localparam logic [4:0] S_R_MUL_LO   = 5'd17;
   localparam logic [4:0] S_R_MUL_HI   = 5'd18;
   localparam logic [4:0] S_R_OUT      = 5'd19;
   localparam logic [4:0] S_G_END      = 5'd20;

   localparam logic signed [41:0] RES_MIN = -42'sd2147483648;

   subj_type            subj_mem [MAX_SUBJECTS];
   logic [RISK_W-1:0]   risk_mem [MAX_SUBJECTS];
   subj_type            subj_rd_ff;
   logic [RISK_W-1:0]   risk_rd_ff;

   logic [4:0]          state_ff, state_in;
   logic                mode_ff;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   last_ff, last_in;
   logic [ADDR_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]   i_ff, i_in;
   logic [ADDR_W-1:0]   grp_ff, grp_in;
   logic [ADDR_W-1:0]   jr_ff, jr_in;
   logic [ADDR_W-1:0]   je_ff, je_in;
   logic [DEATH_W-1:0]  deaths_ff, deaths_in;
   logic [RISK_W-1:0]   efron_ff, efron_in;
   logic [RISK_W-1:0]   denom_ff, denom_in;
   logic [RISK_W-1:0]   den_e_ff, den_e_in;
   logic [TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic                first_ff, first_in;
   logic                strat_ff, strat_in;
   logic                epath_ff, epath_in;
   logic [HAZ_W-1:0]    haz_ff, haz_in;
   logic [HAZ_W-1:0]    dterm_ff, dterm_in;
   logic                r_status_ff, r_status_in;
   logic [SCORE_W-1:0]  r_score_ff, r_score_in;
   logic [HAZ_W-1:0]    r_haz_ff, r_haz_in;
   logic [63:0]         lo_ff, lo_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]    rsp_res_ff, rsp_res_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                subj_we;
   logic [ADDR_W-1:0]   subj_waddr;
   subj_type            subj_wdata;
   logic                risk_we;
   logic [ADDR_W-1:0]   risk_waddr;
   logic [RISK_W-1:0]   risk_wdata;
   logic [ADDR_W-1:0]   rd_addr;

   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic                mul_en;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod;

   logic                load;
   logic                final_beat;
   logic [HAZ_W-1:0]    haz_sel;
   logic [49:0]         psum;
   logic [40:0]         pcap;
   logic [41:0]         rdiff;

   cmr_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cmr_mult u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign load       = start && (state_ff == S_IDLE);
   assign final_beat = req_last_subject || (cnt_ff == ADDR_W'(MAX_SUBJECTS - 1));

   always_ff @(posedge clock) begin
      if (subj_we) begin
         subj_mem[subj_waddr] <= subj_wdata;
      end
      subj_rd_ff <= subj_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (risk_we) begin
         risk_mem[risk_waddr] <= risk_wdata;
      end
      risk_rd_ff <= risk_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      grp_in       = grp_ff;
      jr_in        = jr_ff;
      je_in        = je_ff;
      deaths_in    = deaths_ff;
      efron_in     = efron_ff;
      denom_in     = denom_ff;
      den_e_in     = den_e_ff;
      prev_time_in = prev_time_ff;
      first_in     = first_ff;
      strat_in     = strat_ff;
      epath_in     = epath_ff;
      haz_in       = haz_ff;
      dterm_in     = dterm_ff;
      r_status_in  = r_status_ff;
      r_score_in   = r_score_ff;
      r_haz_in     = r_haz_ff;
      lo_in        = lo_ff;
      rsp_valid_in = 1'b0;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;

      subj_we    = 1'b0;
      subj_waddr = cnt_ff;
      subj_wdata.event_time = req_event_time;
      subj_wdata.status     = req_event_status;
      subj_wdata.stratum    = req_stratum_end || final_beat;
      subj_wdata.score      = req_risk_score;
      risk_we    = 1'b0;
      risk_waddr = k_ff + 1'b1;
      risk_wdata = denom_ff;
      rd_addr    = i_ff;
      div_req    = '0;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;

      haz_sel = (epath_ff && subj_rd_ff.status) ? dterm_ff : haz_ff;
      psum    = 50'({prod[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}) + 50'(lo_ff >> FRAC_BITS);
      if (prod[PROD_W-1:FRAC_BITS] != '0 || psum > 50'(PROD_CAP)) begin
         pcap = PROD_CAP;
      end else begin
         pcap = psum[40:0];
      end
      rdiff = 42'({r_status_ff, {FRAC_BITS{1'b0}}}) - 42'(pcap);

      unique case (state_ff)
         S_IDLE: begin
            if (load) begin
               subj_we = 1'b1;
               if (final_beat) begin
                  last_in  = cnt_ff;
                  k_in     = cnt_ff;
                  cnt_in   = '0;
                  first_in = 1'b1;
                  state_in = S_BK_RD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_BK_RD: begin
            rd_addr  = k_ff;
            state_in = S_BK_PROC;
         end
         S_BK_PROC: begin
            // k+1 starts a tie group when k ends a stratum or differs in time
            if (!first_ff &&
                (subj_rd_ff.stratum || subj_rd_ff.event_time != prev_time_ff)) begin
               risk_we = 1'b1;
            end
            denom_in     = (subj_rd_ff.stratum ? '0 : denom_ff) + RISK_W'(subj_rd_ff.score);
            prev_time_in = subj_rd_ff.event_time;
            first_in     = 1'b0;
            if (k_ff == '0) begin
               state_in = S_BK_FIN;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_BK_RD;
            end
         end
         S_BK_FIN: begin
            risk_we    = 1'b1;
            risk_waddr = '0;
            haz_in     = '0;
            efron_in   = '0;
            deaths_in  = '0;
            i_in       = '0;
            grp_in     = '0;
            state_in   = S_F_RD;
         end
         S_F_RD: begin
            rd_addr  = i_ff;
            state_in = S_F_PROC;
         end
         S_F_PROC: begin
            if (i_ff == grp_ff) begin
               denom_in = risk_rd_ff;
            end
            deaths_in = deaths_ff + DEATH_W'(subj_rd_ff.status);
            if (subj_rd_ff.status) begin
               efron_in = efron_ff + RISK_W'(subj_rd_ff.score);
            end
            prev_time_in = subj_rd_ff.event_time;
            strat_in     = subj_rd_ff.stratum;
            if (subj_rd_ff.stratum) begin
               state_in = S_G_START;
            end else begin
               rd_addr  = i_ff + 1'b1;
               state_in = S_F_NEXT;
            end
         end
         S_F_NEXT: begin
            if (subj_rd_ff.event_time != prev_time_ff) begin
               state_in = S_G_START;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         S_G_START: begin
            if (deaths_ff < DEATH_W'(2) || !mode_ff) begin
               epath_in = 1'b0;
               if (deaths_ff == '0) begin
                  jr_in    = grp_ff;
                  state_in = S_R_RD;
               end else if (denom_ff == '0) begin
                  haz_in   = sat_add(haz_ff, SAT_HAZ);
                  jr_in    = grp_ff;
                  state_in = S_R_RD;
               end else begin
                  div_req.go  = 1'b1;
                  div_req.num = DIV_W'(deaths_ff) << (2 * FRAC_BITS);
                  div_req.den = DIV_W'(denom_ff);
                  state_in    = S_B_WAIT;
               end
            end else begin
               epath_in = 1'b1;
               dterm_in = haz_ff;
               je_in    = '0;
               state_in = S_E_CUT_MUL;
            end
         end
         S_B_WAIT: begin
            if (div_rsp.done) begin
               haz_in   = sat_add(haz_ff, HAZ_W'(div_rsp.quot));
               jr_in    = grp_ff;
               state_in = S_R_RD;
            end
         end
         S_E_CUT_MUL: begin
            mul_en   = 1'b1;
            mul_a    = efron_ff;
            mul_b    = MUL_B_W'(je_ff);
            state_in = S_E_CUT_GO;
         end
         S_E_CUT_GO: begin
            div_req.go  = 1'b1;
            div_req.num = prod[DIV_W-1:0];
            div_req.den = DIV_W'(deaths_ff);
            state_in    = S_E_CUT_WAIT;
         end
         S_E_CUT_WAIT: begin
            if (div_rsp.done) begin
               if (DIV_W'(denom_ff) > div_rsp.quot) begin
                  den_e_in = denom_ff - div_rsp.quot[RISK_W-1:0];
               end else begin
                  den_e_in = '0;
               end
               state_in = S_E_HAZ;
            end
         end
         S_E_HAZ: begin
            mul_en = 1'b1;
            mul_a  = den_e_ff;
            mul_b  = MUL_B_W'(deaths_ff);
            if (den_e_ff == '0) begin
               haz_in   = sat_add(haz_ff, SAT_HAZ);
               state_in = S_E_DT_GO;
            end else begin
               div_req.go  = 1'b1;
               div_req.num = ONE_2F;
               div_req.den = DIV_W'(den_e_ff);
               state_in    = S_E_HAZ_WAIT;
            end
         end
         S_E_HAZ_WAIT: begin
            if (div_rsp.done) begin
               haz_in   = sat_add(haz_ff, HAZ_W'(div_rsp.quot));
               state_in = S_E_DT_GO;
            end
         end
         S_E_DT_GO: begin
            if (den_e_ff == '0) begin
               dterm_in = sat_add(dterm_ff, SAT_HAZ);
               if (DEATH_W'(je_ff) + 1'b1 == deaths_ff) begin
                  jr_in    = grp_ff;
                  state_in = S_R_RD;
               end else begin
                  je_in    = je_ff + 1'b1;
                  state_in = S_E_CUT_MUL;
               end
            end else begin
               div_req.go  = 1'b1;
               div_req.num = DIV_W'(deaths_ff - DEATH_W'(je_ff)) << (2 * FRAC_BITS);
               div_req.den = prod[DIV_W-1:0];
               state_in    = S_E_DT_WAIT;
            end
         end
         S_E_DT_WAIT: begin
            if (div_rsp.done) begin
               dterm_in = sat_add(dterm_ff, HAZ_W'(div_rsp.quot));
               if (DEATH_W'(je_ff) + 1'b1 == deaths_ff) begin
                  jr_in    = grp_ff;
                  state_in = S_R_RD;
               end else begin
                  je_in    = je_ff + 1'b1;
                  state_in = S_E_CUT_MUL;
               end
            end
         end
         S_R_RD: begin
            rd_addr  = jr_ff;
            state_in = S_R_MUL_LO;
         end
         S_R_MUL_LO: begin
            r_status_in = subj_rd_ff.status;
            r_score_in  = subj_rd_ff.score;
            r_haz_in    = haz_sel;
            mul_en      = 1'b1;
            mul_a       = MUL_A_W'(subj_rd_ff.score);
            mul_b       = haz_sel[31:0];
            state_in    = S_R_MUL_HI;
         end
         S_R_MUL_HI: begin
            lo_in    = prod[63:0];
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(r_score_ff);
            mul_b    = MUL_B_W'(r_haz_ff[HAZ_W-1:32]);
            state_in = S_R_OUT;
         end
         S_R_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (jr_ff == last_ff);
            if ($signed(rdiff) < RES_MIN) begin
               rsp_res_in = {1'b1, {(RES_W-1){1'b0}}};
            end else begin
               rsp_res_in = rdiff[RES_W-1:0];
            end
            if (jr_ff == i_ff) begin
               state_in = S_G_END;
            end else begin
               jr_in    = jr_ff + 1'b1;
               state_in = S_R_RD;
            end
         end
         S_G_END: begin
            if (strat_ff) begin
               haz_in = '0;
            end
            deaths_in = '0;
            efron_in  = '0;
            if (i_ff == last_ff) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               grp_in   = i_ff + 1'b1;
               state_in = S_F_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
      last_ff      <= last_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      grp_ff       <= grp_in;
      jr_ff        <= jr_in;
      je_ff        <= je_in;
      deaths_ff    <= deaths_in;
      efron_ff     <= efron_in;
      denom_ff     <= denom_in;
      den_e_ff     <= den_e_in;
      prev_time_ff <= prev_time_in;
      first_ff     <= first_in;
      strat_ff     <= strat_in;
      epath_ff     <= epath_in;
      haz_ff       <= haz_in;
      dterm_ff     <= dterm_in;
      r_status_ff  <= r_status_in;
      r_score_ff   <= r_score_in;
      r_haz_ff     <= r_haz_in;
      lo_ff        <= lo_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_residual    = $signed(rsp_res_ff);
   assign rsp_last_result = rsp_last_ff;

endmodule

>>> sv/cmr_divider.sv
module cmr_divider
   import cmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [DIV_W-1:0]         den_ff, den_in;
   logic [$clog2(DIV_W+1)-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_W:0]           rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (req.go) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = ($clog2(DIV_W+1))'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

>>> sv/cmr_mult.sv
module cmr_mult
   import cmr_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [PROD_W-1:0]  prod
);

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(a) * PROD_W'(b);
      end
   end

   assign prod = prod_ff;

endmodule

>>> dv/tb_cox_martingale_residual.sv
`default_nettype none

module tb_cox_martingale_residual;
   import cmr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic MODE_BRESLOW = 1'b0;
   localparam logic MODE_EFRON   = 1'b1;
   localparam longint unsigned HAZ_MAX = (64'd1 << 48) - 64'd1;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [TIME_W-1:0]       req_event_time;
   logic                    req_event_status;
   logic                    req_stratum_end;
   logic [SCORE_W-1:0]      req_risk_score;
   logic                    req_last_subject;
   logic                    rsp_valid;
   logic signed [RES_W-1:0] rsp_residual;
   logic                    rsp_last_result;
   logic                    csr_we;
   logic                    csr_wdata;

   cox_martingale_residual DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_event_time(req_event_time), .req_event_status(req_event_status),
      .req_stratum_end(req_stratum_end), .req_risk_score(req_risk_score),
      .req_last_subject(req_last_subject),
      .rsp_valid(rsp_valid), .rsp_residual(rsp_residual),
      .rsp_last_result(rsp_last_result),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [RES_W-1:0] residual;
      logic             last_result;
   } resid_beat_type;

   typedef struct packed {
      logic [TIME_W-1:0]  event_time;
      logic               status;
      logic               stratum;
      logic [SCORE_W-1:0] score;
      logic               last;
      logic               mode;
      logic               has_exp;
      logic [RES_W-1:0]   exp_residual;
   } row_type;

   resid_beat_type residual_q[$];
   subj_type       subj_mem[MAX_SUBJECTS];
   int             loaded;
   logic           tie_mode;
   int             errors;
   int             cycles;
   bit             quiet_span;

   function automatic longint unsigned haz_add(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > HAZ_MAX) ? HAZ_MAX : s;
   endfunction

   function automatic longint unsigned haz_div(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (num == 0) return 0;
      if (den == 0) return HAZ_MAX;
      q = num / den;
      return (q > HAZ_MAX) ? HAZ_MAX : q;
   endfunction

   // status minus score * hazard, product capped at 2^40, clamped to 32 bits signed
   function automatic logic [RES_W-1:0] martingale(logic status, logic [31:0] score,
                                                   longint unsigned haz);
      longint unsigned hi, lo, prod;
      longint          v;
      hi = longint'(score) * (haz >> 32);
      lo = longint'(score) * (haz & 64'hFFFF_FFFF);
      if (hi >= (64'd1 << FRAC_BITS)) prod = 64'd1 << 40;
      else begin
         prod = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
         if (prod > (64'd1 << 40)) prod = 64'd1 << 40;
      end
      v = (status ? (64'sd1 << FRAC_BITS) : 64'sd0) - longint'(prod);
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return v[31:0];
   endfunction

   task automatic predict_residuals(int n);
      longint unsigned risk[MAX_SUBJECTS];
      logic [RES_W-1:0] res[MAX_SUBJECTS];
      longint unsigned denom, haz, dterm, eacc, cut, den;
      int grp, deaths;
      resid_beat_type b;
      denom = 0;
      subj_mem[n-1].stratum = 1'b1;
      for (int k = n - 1; k >= 0; k--) begin
         if (subj_mem[k].stratum) denom = 0;
         denom += subj_mem[k].score;
         if (k == 0 || subj_mem[k-1].stratum ||
             subj_mem[k-1].event_time != subj_mem[k].event_time) risk[k] = denom;
      end
      haz = 0; eacc = 0; denom = 0; grp = 0; deaths = 0;
      for (int i = 0; i < n; i++) begin
         if (i == grp) denom = risk[i];
         deaths += subj_mem[i].status;
         if (subj_mem[i].status) eacc += subj_mem[i].score;
         if (subj_mem[i].stratum || subj_mem[i+1].event_time != subj_mem[i].event_time) begin
            if (deaths < 2 || tie_mode == MODE_BRESLOW) begin
               haz = haz_add(haz, haz_div(longint'(deaths) << (2 * FRAC_BITS), denom));
               for (int j = grp; j <= i; j++)
                  res[j] = martingale(subj_mem[j].status, subj_mem[j].score, haz);
            end else begin
               dterm = haz;
               for (int j = 0; j < deaths; j++) begin
                  cut = (eacc * j) / deaths;
                  den = (denom > cut) ? denom - cut : 0;
                  haz = haz_add(haz, haz_div(64'd1 << (2 * FRAC_BITS), den));
                  dterm = haz_add(dterm, haz_div(longint'(deaths - j) << (2 * FRAC_BITS),
                                                 longint'(deaths) * den));
               end
               for (int j = grp; j <= i; j++)
                  res[j] = subj_mem[j].status ? martingale(1'b1, subj_mem[j].score, dterm)
                                              : martingale(1'b0, subj_mem[j].score, haz);
            end
            if (subj_mem[i].stratum) haz = 0;
            grp = i + 1;
            deaths = 0;
            eacc = 0;
         end
      end
      for (int i = 0; i < n; i++) begin
         b.residual = res[i];
         b.last_result = (i == n - 1);
         residual_q.push_back(b);
      end
   endtask

   // called at a rising edge; returns at the edge that takes the beat
   task automatic load_subject(logic [31:0] t, logic st, logic se, logic [31:0] sc,
                               logic last, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_event_time <= t;
      req_event_status <= st;
      req_stratum_end <= se;
      req_risk_score <= sc;
      req_last_subject <= last;
      do @(posedge clock); while (busy);
      subj_mem[loaded].event_time = t;
      subj_mem[loaded].status = st;
      subj_mem[loaded].stratum = se;
      subj_mem[loaded].score = sc;
      loaded++;
      if (last || loaded == MAX_SUBJECTS) begin
         predict_residuals(loaded);
         loaded = 0;
      end
   endtask

   task automatic write_tie_mode(logic m);
      start <= 1'b0;
      @(posedge clock);
      while (residual_q.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      tie_mode = m;
   endtask

   function automatic int pick_gap();
      if (quiet_span || $urandom_range(0, 99) >= 12) return 0;
      return 1;
   endfunction

   function automatic logic [31:0] pick_score();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(1, 32'h0003_0000);
      endcase
   endfunction

   always @(posedge clock) begin
      resid_beat_type e;
      if (!reset && rsp_valid) begin
         if (residual_q.size() == 0) begin
            $error("residual beat with nothing expected: %h", rsp_residual);
            errors++;
         end else begin
            e = residual_q.pop_front();
            if (rsp_residual !== e.residual) begin
               $error("residual: expected %h, got %h", e.residual, rsp_residual);
               errors++;
            end
            if (rsp_last_result !== e.last_result) begin
               $error("last_result: expected %b, got %b", e.last_result, rsp_last_result);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   row_type directed[18] = '{
      '{32'd0,        1'b1, 1'b0, 32'h0001_0000, 1'b1, MODE_BRESLOW, 1'b1, 32'd0},
      '{32'd0,        1'b0, 1'b0, 32'd0,         1'b1, MODE_BRESLOW, 1'b1, 32'd0},
      // death with zero risk set: hazard saturates, product is still zero
      '{32'd7,        1'b1, 1'b0, 32'd0,         1'b1, MODE_BRESLOW, 1'b1, 32'h0001_0000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, MODE_BRESLOW, 1'b1, 32'd1},
      '{32'd5,        1'b1, 1'b0, 32'h0000_8000, 1'b0, MODE_BRESLOW, 1'b0, 32'd0},
      '{32'd5,        1'b1, 1'b0, 32'h0001_8000, 1'b0, MODE_BRESLOW, 1'b0, 32'd0},
      '{32'd5,        1'b0, 1'b0, 32'h0001_0000, 1'b0, MODE_BRESLOW, 1'b0, 32'd0},
      '{32'd9,        1'b1, 1'b0, 32'h0000_4000, 1'b1, MODE_BRESLOW, 1'b0, 32'd0},
      '{32'd5,        1'b1, 1'b0, 32'h0000_8000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd5,        1'b1, 1'b0, 32'h0001_8000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd5,        1'b1, 1'b0, 32'h0001_0000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd9,        1'b0, 1'b0, 32'h0000_4000, 1'b1, MODE_EFRON,   1'b0, 32'd0},
      // lone death in Efron mode takes the Breslow step
      '{32'd3,        1'b1, 1'b0, 32'h0001_0000, 1'b1, MODE_EFRON,   1'b1, 32'd0},
      '{32'd1,        1'b1, 1'b0, 32'h0002_0000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd2,        1'b1, 1'b1, 32'h0001_0000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd1,        1'b1, 1'b0, 32'h0001_0000, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd1,        1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, MODE_EFRON,   1'b0, 32'd0},
      '{32'd1,        1'b0, 1'b0, 32'h0000_0001, 1'b1, MODE_EFRON,   1'b0, 32'd0}
   };

   initial begin
      int items, n, full_sets;
      logic [31:0] t;
      bit first;
      clock = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_event_time <= '0;
      req_event_status <= 1'b0;
      req_stratum_end <= 1'b0;
      req_risk_score <= '0;
      req_last_subject <= 1'b0;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      loaded = 0;
      tie_mode = MODE_BRESLOW;
      quiet_span = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_tie_mode(MODE_BRESLOW);

      first = 1;
      foreach (directed[r]) begin
         if (first && directed[r].mode != tie_mode) write_tie_mode(directed[r].mode);
         load_subject(directed[r].event_time, directed[r].status, directed[r].stratum,
                      directed[r].score, directed[r].last, pick_gap());
         if (directed[r].has_exp) residual_q[$].residual = directed[r].exp_residual;
         first = directed[r].last;
      end

      items = 0;
      full_sets = 0;
      while (items < 310) begin
         if ($urandom_range(0, 9) < 3) write_tie_mode(1'($urandom_range(0, 1)));
         if (full_sets < 2 && items > 60 * (full_sets + 1)) begin
            n = MAX_SUBJECTS;
            full_sets++;
         end else n = $urandom_range(1, 10);
         quiet_span = (items >= 120 && items < 190);
         t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) t = $urandom;
            else t = t + $urandom_range(0, 2) * ($urandom_range(0, 2) != 0);
            // full store ends the set even without last_subject
            load_subject(t, 1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0,
                         pick_score(),
                         (i == n - 1) && !(n == MAX_SUBJECTS && full_sets == 2),
                         pick_gap());
            items++;
         end
      end

      start <= 1'b0;
      req_last_subject <= 1'b0;
      @(posedge clock);
      while (residual_q.size() != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && residual_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
